// ----- design/ssp_pkg.sv -----
// Shared types and constants for the step sequencer playhead core.
// Used by every module of the block but ssp_ram; has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

    localparam int MAX_STEPS_DEF = 1024;

    localparam int SEQ_LEN_W = 11;
    localparam int INDEX_W   = 10;
    localparam int DUR_W     = 7;
    localparam int CV_W      = 7;
    localparam int POS_W     = 10;
    localparam int TICK_W    = 7;

    localparam logic [SEQ_LEN_W-1:0] SEQ_LEN_RESET = 11'd1;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [INDEX_W-1:0] step_index;
        logic [DUR_W-1:0]   step_duration;
        logic [CV_W-1:0]    step_cv;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  play_position;
        logic [TICK_W-1:0] hold_count;
        logic              note_fired;
        logic [CV_W-1:0]   note_cv;
    } out_item_t;

    typedef struct packed {
        logic clr_wr;
        logic step_wr;
        logic tick_start;
        logic scan_rd;
        logic result_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic scan_last;
    } dp_sts_t;

endpackage

`default_nettype wire

// ----- design/ssp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ssp_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/ssp_ctrl.sv -----
// Controller FSM: clearing pass, request intake, step scan and result hand-off.
// Depends on ssp_pkg; drives ssp_dpath through command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module ssp_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    input  wire logic            s_mode,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output ssp_pkg::dp_cmd_t     cmd,
    input  wire ssp_pkg::dp_sts_t sts
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_mode == ssp_pkg::MODE_TICK) begin
                        cmd.tick_start = 1'b1;
                        state_next     = ST_SCAN;
                    end else begin
                        cmd.step_wr = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    cmd.result_load = 1'b1;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ----- design/ssp_dpath.sv -----
// Datapath: length register, step RAM, scan counter, search flags, playhead
// and result register. Depends on ssp_pkg and ssp_ram; steered by ssp_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ssp_dpath #(
    parameter int MAX_STEPS = ssp_pkg::MAX_STEPS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire ssp_pkg::dp_cmd_t                cmd,
    output ssp_pkg::dp_sts_t                     sts,
    input  wire ssp_pkg::in_item_t               s_data,
    input  wire logic                            cfg_we,
    input  wire logic [ssp_pkg::SEQ_LEN_W-1:0]   cfg_data,
    output ssp_pkg::out_item_t                   m_data
);

    localparam int AW = $clog2(MAX_STEPS);
    localparam int LW = $clog2(MAX_STEPS + 1);
    localparam int CW = (LW > ssp_pkg::SEQ_LEN_W) ? LW : ssp_pkg::SEQ_LEN_W;
    localparam int DUR_W  = ssp_pkg::DUR_W;
    localparam int CV_W   = ssp_pkg::CV_W;
    localparam int TICK_W = ssp_pkg::TICK_W;
    localparam int DW     = DUR_W + CV_W;

    logic [ssp_pkg::SEQ_LEN_W-1:0] seq_len_reg;
    logic [AW-1:0]                 cnt_reg;
    logic [AW-1:0]                 ph_reg;
    logic [TICK_W-1:0]             tick_reg;
    logic                          rd_vld_reg;
    logic [AW-1:0]                 rd_idx_reg;
    logic                          any_reg;
    logic                          first_found_reg;
    logic [AW-1:0]                 first_idx_reg;
    logic [CV_W-1:0]               first_cv_reg;
    logic                          next_found_reg;
    logic [AW-1:0]                 next_idx_reg;
    logic [CV_W-1:0]               next_cv_reg;
    logic [DUR_W-1:0]              cur_dur_reg;
    logic [CV_W-1:0]               cur_cv_reg;
    ssp_pkg::out_item_t            out_reg;

    logic [LW-1:0]     eff_len;
    logic [AW-1:0]     last_addr;
    logic [AW-1:0]     ph_fixed;
    logic              wr_in_range;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DW-1:0]     ram_wdata;
    logic [DW-1:0]     ram_rdata;
    logic [DUR_W-1:0]  rd_dur;
    logic [CV_W-1:0]   rd_cv;
    logic              rd_nz;
    logic [AW-1:0]     ph_next;
    logic [TICK_W-1:0] tick_next;
    logic              fired_next;
    logic [CV_W-1:0]   cv_next;

    assign eff_len = (CW'(seq_len_reg) > CW'(MAX_STEPS)) ? LW'(MAX_STEPS) : LW'(seq_len_reg);
    assign last_addr = (eff_len == '0) ? '0 : AW'(eff_len - LW'(1));
    assign ph_fixed  = (LW'(ph_reg) >= eff_len) ? '0 : ph_reg;

    assign sts.clr_last  = (cnt_reg == AW'(MAX_STEPS - 1));
    assign sts.scan_last = (cnt_reg == last_addr);

    // Step RAM: duration in the upper field, cv in the lower.
    assign wr_in_range = (32'(s_data.step_index) < 32'(MAX_STEPS));
    assign ram_we      = cmd.clr_wr || (cmd.step_wr && wr_in_range);
    assign ram_waddr   = cmd.clr_wr ? cnt_reg : AW'(s_data.step_index);
    assign ram_wdata   = cmd.clr_wr ? '0 : {s_data.step_duration, s_data.step_cv};

    ssp_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_STEPS)
    ) u_step_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.scan_rd),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    assign rd_dur = ram_rdata[DW-1:CV_W];
    assign rd_cv  = ram_rdata[CV_W-1:0];
    assign rd_nz  = rd_vld_reg && (LW'(rd_idx_reg) < eff_len) && (rd_dur != '0);

    always_comb begin
        ph_next    = ph_reg;
        tick_next  = tick_reg;
        fired_next = 1'b0;
        cv_next    = cur_cv_reg;
        if (any_reg) begin
            if ((cur_dur_reg != '0) &&
                ((9'(tick_reg) + 9'd1) < 9'(cur_dur_reg))) begin
                tick_next = tick_reg + TICK_W'(1);
            end else begin
                tick_next = '0;
                priority if (next_found_reg) begin
                    ph_next    = next_idx_reg;
                    cv_next    = next_cv_reg;
                    fired_next = 1'b1;
                end else if (first_found_reg && (first_idx_reg != ph_reg)) begin
                    ph_next    = first_idx_reg;
                    cv_next    = first_cv_reg;
                    fired_next = 1'b1;
                end else begin
                    ph_next = ph_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_len_reg <= ssp_pkg::SEQ_LEN_RESET;
            cnt_reg     <= '0;
            ph_reg      <= '0;
            tick_reg    <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                seq_len_reg <= cfg_data;
            end
            if (cmd.clr_wr || cmd.scan_rd) begin
                cnt_reg <= cnt_reg + AW'(1);
            end else if (cmd.tick_start) begin
                cnt_reg <= '0;
            end
            if (cmd.tick_start) begin
                ph_reg <= ph_fixed;
            end else if (cmd.result_load) begin
                ph_reg   <= ph_next;
                tick_reg <= tick_next;
            end
            rd_vld_reg <= cmd.scan_rd;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= cnt_reg;
        if (cmd.tick_start) begin
            any_reg         <= 1'b0;
            first_found_reg <= 1'b0;
            next_found_reg  <= 1'b0;
        end else begin
            if (rd_nz) begin
                any_reg <= 1'b1;
                if (!first_found_reg) begin
                    first_found_reg <= 1'b1;
                    first_idx_reg   <= rd_idx_reg;
                    first_cv_reg    <= rd_cv;
                end
                if (!next_found_reg && (rd_idx_reg > ph_reg)) begin
                    next_found_reg <= 1'b1;
                    next_idx_reg   <= rd_idx_reg;
                    next_cv_reg    <= rd_cv;
                end
            end
            if (rd_vld_reg && (rd_idx_reg == ph_reg)) begin
                cur_dur_reg <= rd_dur;
                cur_cv_reg  <= rd_cv;
            end
        end
        if (cmd.result_load) begin
            out_reg.play_position <= ssp_pkg::POS_W'(ph_next);
            out_reg.hold_count    <= tick_next;
            out_reg.note_fired    <= fired_next;
            out_reg.note_cv       <= cv_next;
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

// ----- design/step_sequencer_playhead_core.sv -----
// Top level of the step sequencer playhead: request/result channels and
// length register port. Depends on ssp_pkg, ssp_ctrl, ssp_dpath (ssp_ram).
`timescale 1ns / 1ps
`default_nettype none

// Step sequencer playhead. A write request (mode 0) stores one step's duration
// and cv. A tick request (mode 1) scans the step RAM one entry per cycle over
// L = max(min(sequence_length, MAX_STEPS), 1) entries and returns one result.
// After reset the step RAM is cleared in a pass over all MAX_STEPS entries,
// during which s_ready stays low. cfg_ready is always high; write the length
// only while no tick is in flight. The result register lets a finished result
// wait on m_ready while new requests are taken.
module step_sequencer_playhead_core #(
    parameter int MAX_STEPS = ssp_pkg::MAX_STEPS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire ssp_pkg::in_item_t             s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output ssp_pkg::out_item_t                 m_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ssp_pkg::SEQ_LEN_W-1:0] cfg_data
);

    ssp_pkg::dp_cmd_t cmd;
    ssp_pkg::dp_sts_t sts;
    logic             cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    ssp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_data.mode),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    ssp_dpath #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_data   (s_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

// ----- sim/ssp_checker.sv -----
// Result checker for the step sequencer playhead core: follows the request,
// result and length channels and checks every result against its prediction.
// Depends on ssp_pkg.
`timescale 1ns / 1ps

module ssp_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  ssp_pkg::in_item_t             s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  ssp_pkg::out_item_t            m_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [ssp_pkg::SEQ_LEN_W-1:0] cfg_data,
    output int                            mismatches,
    output int                            outstanding
);
    import ssp_pkg::*;

    logic [DUR_W-1:0]     dur_mem [MAX_STEPS_DEF];
    logic [CV_W-1:0]      cv_mem  [MAX_STEPS_DEF];
    logic [POS_W-1:0]     head;
    logic [TICK_W-1:0]    held;
    logic [SEQ_LEN_W-1:0] seq_len;
    out_item_t            pending_q[$];
    out_item_t            want;
    int                   i;

    task automatic log_error(input string msg);
        $display("[%0t] ERROR %s", $time, msg);
        mismatches++;
    endtask

    // Advances the playhead by one tick and returns the result it produces.
    function automatic out_item_t predict_tick();
        int        span_len;
        int        k;
        int        j;
        bit        any_on;
        bit        found;
        out_item_t r;
        span_len = (seq_len > MAX_STEPS_DEF) ? MAX_STEPS_DEF : int'(seq_len);
        if (int'(head) >= span_len) head = '0;
        any_on = 1'b0;
        for (k = 0; k < span_len; k++) begin
            if (dur_mem[k] != 0) any_on = 1'b1;
        end
        found = 1'b0;
        if (any_on) begin
            if (dur_mem[head] != 0 && int'(held) + 1 < int'(dur_mem[head])) begin
                held = held + 1'b1;
            end else begin
                held = '0;
                for (k = 1; k < span_len && !found; k++) begin
                    j = int'(head) + k;
                    if (j >= span_len) j -= span_len;
                    if (dur_mem[j] != 0) begin
                        head  = POS_W'(j);
                        found = 1'b1;
                    end
                end
            end
        end
        r.play_position = head;
        r.hold_count    = held;
        r.note_fired    = found;
        r.note_cv       = cv_mem[head];
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (i = 0; i < MAX_STEPS_DEF; i++) begin
                dur_mem[i] = '0;
                cv_mem[i]  = '0;
            end
            head    = '0;
            held    = '0;
            seq_len = SEQ_LEN_RESET;
            pending_q.delete();
        end else begin
            // retire the result first: a request taken at this edge cannot be its source
            if (m_valid && m_ready) begin
                if (pending_q.size() == 0) begin
                    log_error($sformatf("result with none pending: pos %0d",
                                        m_data.play_position));
                end else begin
                    want = pending_q.pop_front();
                    if (m_data.play_position !== want.play_position)
                        log_error($sformatf("play_position got %0d want %0d",
                                            m_data.play_position, want.play_position));
                    if (m_data.hold_count !== want.hold_count)
                        log_error($sformatf("hold_count got %0d want %0d",
                                            m_data.hold_count, want.hold_count));
                    if (m_data.note_fired !== want.note_fired)
                        log_error($sformatf("note_fired got %0d want %0d",
                                            m_data.note_fired, want.note_fired));
                    if (m_data.note_cv !== want.note_cv)
                        log_error($sformatf("note_cv got %0d want %0d",
                                            m_data.note_cv, want.note_cv));
                end
            end
            if (cfg_valid && cfg_ready) seq_len = cfg_data;
            if (s_valid && s_ready) begin
                if (s_data.mode == MODE_TICK) begin
                    pending_q.push_back(predict_tick());
                end else begin
                    dur_mem[s_data.step_index] = s_data.step_duration;
                    cv_mem[s_data.step_index]  = s_data.step_cv;
                end
            end
        end
        outstanding = pending_q.size();
    end

endmodule

// ----- sim/testbench.sv -----
// Top of the step sequencer playhead regression: clock, reset, request and
// length stimulus, and the verdict. Depends on ssp_pkg, ssp_checker and the core.
`timescale 1ns / 1ps

module testbench;
    import ssp_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_WAIT  = 8;
    localparam int TAIL_WAIT    = 1100;
    localparam int IDLE_PCT     = 6;
    localparam int NUM_PHASES   = 10;
    localparam int STEADY_PHASE = 2;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [SEQ_LEN_W-1:0] cfg_data  = '0;
    int                   mismatches;
    int                   outstanding;
    bit                   steady_run = 1'b0;
    int                   cycle_count = 0;

    // -1 picks a random short length
    int phase_len   [NUM_PHASES] = '{8, 3, 16, 32, 5, 1, 0, 1024, 2047, -1};
    int phase_items [NUM_PHASES] = '{90, 60, 90, 80, 60, 30, 20, 40, 30, 80};

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
    end

    step_sequencer_playhead_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ssp_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    task automatic push_request(input logic mode, input logic [INDEX_W-1:0] idx,
                                input logic [DUR_W-1:0] dur, input logic [CV_W-1:0] cv);
        in_item_t req;
        req.mode          = mode;
        req.step_index    = idx;
        req.step_duration = dur;
        req.step_cv       = cv;
        while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        @(posedge aclk);
    endtask

    task automatic set_length(input int len);
        wait_drained();
        repeat (SETTLE_WAIT) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= SEQ_LEN_W'(len);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int                 p;
        int                 n;
        int                 len;
        int                 span;
        int                 r;
        logic [INDEX_W-1:0] idx;
        logic [DUR_W-1:0]   dur;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset length of one: nothing on, then a lone step, then a step past the end
        push_request(MODE_TICK, '0, '0, '0);
        push_request(MODE_WRITE, 10'd0, 7'd1, 7'd127);
        push_request(MODE_TICK, 10'd1023, 7'd127, 7'd127);
        push_request(MODE_WRITE, 10'd1023, 7'd127, 7'd127);
        push_request(MODE_TICK, '0, '0, '0);

        set_length(4);
        push_request(MODE_WRITE, 10'd1, 7'd2, 7'd85);
        push_request(MODE_WRITE, 10'd3, 7'd127, 7'd0);
        push_request(MODE_TICK, '0, '0, '0);
        push_request(MODE_TICK, '0, '0, '0);
        push_request(MODE_TICK, '0, '0, '0);
        push_request(MODE_TICK, '0, '0, '0);
        // current step switched off under the playhead
        push_request(MODE_WRITE, 10'd3, 7'd0, 7'd42);
        push_request(MODE_TICK, '0, '0, '0);
        push_request(MODE_WRITE, 10'd0, 7'd0, 7'd0);
        push_request(MODE_TICK, '0, '0, '0);
        push_request(MODE_WRITE, 10'd2, 7'd64, 7'd1);
        push_request(MODE_TICK, '0, '0, '0);
        push_request(MODE_TICK, '0, '0, '0);

        for (p = 0; p < NUM_PHASES; p++) begin
            len = (phase_len[p] < 0) ? $urandom_range(40, 2) : phase_len[p];
            steady_run <= (p == STEADY_PHASE);
            set_length(len);
            span = (len == 0) ? 8 : ((len > MAX_STEPS_DEF) ? MAX_STEPS_DEF : len);
            for (n = 0; n < phase_items[p]; n++) begin
                if ($urandom_range(99) < 55) begin
                    push_request(MODE_TICK, INDEX_W'($urandom), DUR_W'($urandom),
                                 CV_W'($urandom));
                end else begin
                    idx = ($urandom_range(99) < 85) ? INDEX_W'($urandom_range(span - 1))
                                                    : INDEX_W'($urandom_range(1023));
                    r = $urandom_range(99);
                    if (r < 25)      dur = '0;
                    else if (r < 85) dur = DUR_W'($urandom_range(4, 1));
                    else if (r < 97) dur = DUR_W'($urandom_range(20, 5));
                    else             dur = DUR_W'($urandom_range(127, 100));
                    push_request(MODE_WRITE, idx, dur, CV_W'($urandom_range(127)));
                end
            end
        end

        steady_run <= 1'b0;
        wait_drained();
        repeat (TAIL_WAIT) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
